>>> rtl/core/u16da_pkg.sv
package u16da_pkg;

   // ascii code of the character '0'
   localparam logic [5:0] DIGIT_BASE = 6'd48;

   // number of decimal places in a 16-bit value
   localparam int unsigned NUM_PLACES = 5;

   // place weights, ten-thousands down to tens
   localparam logic [13:0] PLACE_WEIGHT [4] = '{14'd10000, 14'd1000, 14'd100, 14'd10};

   typedef logic [3:0] digit_type;

   // one place of the conversion: the digit and what is left below it
   typedef struct packed {
      digit_type   digit;
      logic [15:0] rest;
   } split_type;

   // pipeline stage contents: remainder and the digits found so far
   typedef struct packed {
      logic [15:0]          rest;
      logic [3:0][3:0]      digits;
   } stage_type;

   // extract one decimal digit by parallel compares against its multiples
   function automatic split_type split_digit(input logic [15:0] rest,
                                             input logic [13:0] weight);
      split_type   res;
      logic [17:0] prod;
      logic [17:0] sub;
      res.digit = '0;
      for (int k = 1; k <= 9; k++) begin
         prod = 18'(k) * {4'b0, weight};
         if ({2'b0, rest} >= prod) begin
            res.digit = 4'(k);
         end
      end
      sub      = {14'b0, res.digit} * {4'b0, weight};
      res.rest = rest - sub[15:0];
      return res;
   endfunction

endpackage

>>> rtl/core/u16_to_decimal_ascii_core.sv
// channel   | ports                              | handshake
// ----------+------------------------------------+----------------------------------
// request   | req_value[15:0]                    | start, taken when busy is low
// response  | rsp_digit_char[5:0], rsp_last_char | rsp_strobe, high for each character
//
// a value passes an input register and four digit stages (one decimal place
// each), then a serializer that sends one character per cycle.
// the first character leaves the serializer once the value has passed every stage.
// throughput is set by the serializer's single character output: one character per
// digit (1 to 5), the next value loading on the last; busy rises as the stages fill.
// synchronous reset empties every stage and the serializer.
// the receiver cannot stall; the stages hold their words while the serializer is busy.
module u16_to_decimal_ascii_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [15:0]               req_value,
   output logic                      rsp_strobe,
   output logic [5:0]                rsp_digit_char,
   output logic                      rsp_last_char
);
   import u16da_pkg::*;

   localparam int unsigned NUM_STAGES = 5;

   stage_type stage_ff [NUM_STAGES];
   stage_type stage_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] go;
   logic [NUM_STAGES-1:0] free;

   logic [4:0][3:0] ser_digits_ff;
   logic [4:0][3:0] ser_digits_in;
   logic [2:0]      ser_idx_ff;
   logic [2:0]      ser_idx_in;
   logic            ser_active_ff;
   logic            ser_active_in;
   logic            ser_take;
   logic [2:0]      first_idx;

   // serializer can take a new word on its last character or when empty
   assign ser_take = !ser_active_ff || (ser_idx_ff == 3'(NUM_PLACES - 1));

   // stage flow control, back to front
   always_comb begin
      for (int j = NUM_STAGES - 1; j >= 0; j--) begin
         if (j == NUM_STAGES - 1) begin
            go[j] = valid_ff[j] && ser_take;
         end else begin
            go[j] = valid_ff[j] && free[j+1];
         end
         free[j] = !valid_ff[j] || go[j];
      end
   end

   assign busy = !free[0];

   // stage data and valid bits
   always_comb begin
      split_type sp;
      sp                 = '0;
      stage_in[0]        = stage_ff[0];
      valid_in[0]        = valid_ff[0] && !go[0];
      if (start && !busy) begin
         stage_in[0].rest   = req_value;
         stage_in[0].digits = '0;
         valid_in[0]        = 1'b1;
      end
      for (int j = 1; j < NUM_STAGES; j++) begin
         stage_in[j] = stage_ff[j];
         valid_in[j] = valid_ff[j] && !go[j];
         if (go[j-1]) begin
            sp                       = split_digit(stage_ff[j-1].rest, PLACE_WEIGHT[j-1]);
            stage_in[j].rest         = sp.rest;
            stage_in[j].digits       = stage_ff[j-1].digits;
            stage_in[j].digits[j-1]  = sp.digit;
            valid_in[j]              = 1'b1;
         end
      end
   end

   // first shown place: first nonzero digit, else the units
   always_comb begin
      first_idx = 3'(NUM_PLACES - 1);
      for (int p = 3; p >= 0; p--) begin
         if (stage_ff[NUM_STAGES-1].digits[p] != '0) begin
            first_idx = 3'(p);
         end
      end
   end

   // serializer: load a word or step to the next character
   always_comb begin
      ser_digits_in = ser_digits_ff;
      ser_idx_in    = ser_idx_ff;
      ser_active_in = ser_active_ff;
      if (ser_active_ff && !ser_take) begin
         ser_idx_in = ser_idx_ff + 3'd1;
      end else if (go[NUM_STAGES-1]) begin
         ser_digits_in[3:0] = stage_ff[NUM_STAGES-1].digits;
         ser_digits_in[4]   = stage_ff[NUM_STAGES-1].rest[3:0];
         ser_idx_in         = first_idx;
         ser_active_in      = 1'b1;
      end else begin
         ser_active_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         ser_active_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         ser_active_ff <= ser_active_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int j = 0; j < NUM_STAGES; j++) begin
         stage_ff[j] <= stage_in[j];
      end
      ser_digits_ff <= ser_digits_in;
      ser_idx_ff    <= ser_idx_in;
   end

   // response word
   assign rsp_strobe     = ser_active_ff;
   assign rsp_digit_char = DIGIT_BASE + {2'b0, ser_digits_ff[ser_idx_ff]};
   assign rsp_last_char  = (ser_idx_ff == 3'(NUM_PLACES - 1));

endmodule

>>> rtl/core/u16da_checker.sv
module u16da_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       busy,
   input  logic       rsp_strobe,
   input  logic [5:0] rsp_digit_char,
   input  logic       rsp_last_char
);
   import u16da_pkg::*;

   // every character sent is a decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_digit_char >= DIGIT_BASE) && (rsp_digit_char <= DIGIT_BASE + 6'd9))
      else $error("character outside '0'..'9'");

   // characters of one number come out in consecutive cycles
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_char |=> rsp_strobe)
      else $error("gap inside a number");

   // a leading zero is only ever sent as the whole number zero
   a_no_leading_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_char && $past(!rsp_strobe || rsp_last_char)
      |-> rsp_digit_char != DIGIT_BASE)
      else $error("leading zero sent");

   // nothing is sent and nothing is held off in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("word sent or busy after reset");

endmodule

bind u16_to_decimal_ascii_core u16da_checker u_u16da_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last_char  (rsp_last_char)
);
